// ===== rtl/ssui_pkg.sv =====
// shared types and constants for the sorted set union / intersection core
// opcodes, status codes, controller states and the result record
// no dependencies
package ssui_pkg;

    localparam int DATA_W = 32;

    localparam logic [2:0] OP_INS_A  = 3'd0;
    localparam logic [2:0] OP_INS_B  = 3'd1;
    localparam logic [2:0] OP_UNION  = 3'd2;
    localparam logic [2:0] OP_ISECT  = 3'd3;
    localparam logic [2:0] OP_CLEAR  = 3'd4;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_DUP   = 2'd1;
    localparam logic [1:0] STATUS_FULL  = 2'd2;
    localparam logic [1:0] STATUS_EMPTY = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_SHIFT,
        ST_MERGE,
        ST_FLUSH,
        ST_RESULT
    } state_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        logic                     has_value;
        logic [1:0]               status;
        logic                     last;
    } res_t;

endpackage

// ===== rtl/ssui_ram.sv =====
// generic single write port / single read port ram with registered read
// no reset on the array or the read register
// no dependencies
module ssui_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/ssui_ctrl.sv =====
// controller for the sorted set core: sorted insert (search then shift),
// merge walk for union / intersection, clear; drives both set rams
// depends on ssui_pkg
module ssui_ctrl
    import ssui_pkg::*;
#(
    parameter int SET_DEPTH = 32,
    parameter int AW        = (SET_DEPTH > 1) ? $clog2(SET_DEPTH) : 1,
    parameter int CW        = $clog2(SET_DEPTH + 1)
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [2:0]               in_opcode,
    input  logic signed [DATA_W-1:0] in_value,
    output logic                     res_valid,
    input  logic                     res_ready,
    output res_t                     res,
    output logic [AW-1:0]            a_raddr,
    output logic [AW-1:0]            b_raddr,
    input  logic signed [DATA_W-1:0] a_rdata,
    input  logic signed [DATA_W-1:0] b_rdata,
    output logic                     a_we,
    output logic                     b_we,
    output logic [AW-1:0]            wr_addr,
    output logic [DATA_W-1:0]        wr_data
);

    state_t                   state_reg, state_next;
    logic [2:0]               op_reg, op_next;
    logic signed [DATA_W-1:0] val_reg, val_next;
    logic [CW-1:0]            i_reg, i_next;
    logic [CW-1:0]            j_reg, j_next;
    logic [CW-1:0]            cnt_a_reg, cnt_a_next;
    logic [CW-1:0]            cnt_b_reg, cnt_b_next;
    logic [1:0]               status_reg, status_next;
    logic signed [DATA_W-1:0] pend_reg, pend_next;
    logic                     pend_valid_reg, pend_valid_next;

    logic                     sel_b;
    logic                     is_union;
    logic signed [DATA_W-1:0] rd;
    logic [CW-1:0]            n_sel;
    logic                     have_a, have_b;
    logic signed [DATA_W-1:0] mv;
    logic                     emit;
    logic                     adv_a, adv_b;
    logic [CW-1:0]            ins_addr;
    logic [CW-1:0]            ra_full, rb_full;

    assign sel_b    = (op_reg == OP_INS_B);
    assign is_union = (op_reg == OP_UNION);
    assign rd       = sel_b ? b_rdata : a_rdata;
    assign n_sel    = sel_b ? cnt_b_reg : cnt_a_reg;
    assign have_a   = (i_reg < cnt_a_reg);
    assign have_b   = (j_reg < cnt_b_reg);
    assign in_ready = (state_reg == ST_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            cnt_a_reg      <= '0;
            cnt_b_reg      <= '0;
            pend_valid_reg <= 1'b0;
            i_reg          <= '0;
            j_reg          <= '0;
            op_reg         <= OP_INS_A;
            status_reg     <= STATUS_OK;
        end
        else
        begin
            state_reg      <= state_next;
            cnt_a_reg      <= cnt_a_next;
            cnt_b_reg      <= cnt_b_next;
            pend_valid_reg <= pend_valid_next;
            i_reg          <= i_next;
            j_reg          <= j_next;
            op_reg         <= op_next;
            status_reg     <= status_next;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg  <= val_next;
        pend_reg <= pend_next;
    end

    // merge candidate from the two current heads
    always_comb
    begin
        mv    = a_rdata;
        emit  = is_union;
        adv_a = 1'b0;
        adv_b = 1'b0;
        if (have_a && have_b)
        begin
            if (a_rdata > b_rdata)
            begin
                adv_a = 1'b1;
            end
            else if (b_rdata > a_rdata)
            begin
                mv    = b_rdata;
                adv_b = 1'b1;
            end
            else
            begin
                emit  = 1'b1;
                adv_a = 1'b1;
                adv_b = 1'b1;
            end
        end
        else if (have_a)
        begin
            adv_a = 1'b1;
        end
        else
        begin
            mv    = b_rdata;
            adv_b = 1'b1;
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        op_next         = op_reg;
        val_next        = val_reg;
        i_next          = i_reg;
        j_next          = j_reg;
        cnt_a_next      = cnt_a_reg;
        cnt_b_next      = cnt_b_reg;
        status_next     = status_reg;
        pend_next       = pend_reg;
        pend_valid_next = pend_valid_reg;
        res_valid       = 1'b0;
        res             = '0;
        a_we            = 1'b0;
        b_we            = 1'b0;
        wr_addr         = j_reg[AW-1:0];
        wr_data         = (j_reg == i_reg) ? val_reg : rd;

        unique case (state_reg)
            ST_IDLE:
            begin
                i_next = '0;
                j_next = '0;
                if (in_valid)
                begin
                    op_next  = in_opcode;
                    val_next = in_value;
                    case (in_opcode)
                        OP_INS_A, OP_INS_B:
                        begin
                            state_next = ST_SEARCH;
                        end
                        OP_UNION, OP_ISECT:
                        begin
                            pend_valid_next = 1'b0;
                            state_next      = ST_MERGE;
                        end
                        OP_CLEAR:
                        begin
                            cnt_a_next  = '0;
                            cnt_b_next  = '0;
                            status_next = STATUS_OK;
                            state_next  = ST_RESULT;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end

            // rd holds entry i of the target set
            ST_SEARCH:
            begin
                if ((i_reg < n_sel) && (rd > val_reg))
                begin
                    i_next = i_reg + CW'(1);
                end
                else if ((i_reg < n_sel) && (rd == val_reg))
                begin
                    status_next = STATUS_DUP;
                    state_next  = ST_RESULT;
                end
                else if (n_sel == CW'(SET_DEPTH))
                begin
                    status_next = STATUS_FULL;
                    state_next  = ST_RESULT;
                end
                else
                begin
                    j_next     = n_sel;
                    state_next = ST_SHIFT;
                end
            end

            // rd holds entry j-1; move it up to j until j reaches the slot
            ST_SHIFT:
            begin
                a_we = !sel_b;
                b_we = sel_b;
                if (j_reg == i_reg)
                begin
                    if (sel_b)
                    begin
                        cnt_b_next = cnt_b_reg + CW'(1);
                    end
                    else
                    begin
                        cnt_a_next = cnt_a_reg + CW'(1);
                    end
                    status_next = STATUS_OK;
                    state_next  = ST_RESULT;
                end
                else
                begin
                    j_next = j_reg - CW'(1);
                end
            end

            // one value held back so the final one can carry last
            ST_MERGE:
            begin
                if (!have_a && !have_b)
                begin
                    state_next = ST_FLUSH;
                end
                else
                begin
                    res_valid     = emit && pend_valid_reg;
                    res.value     = pend_reg;
                    res.has_value = 1'b1;
                    res.status    = STATUS_OK;
                    res.last      = 1'b0;
                    if (!res_valid || res_ready)
                    begin
                        if (adv_a)
                        begin
                            i_next = i_reg + CW'(1);
                        end
                        if (adv_b)
                        begin
                            j_next = j_reg + CW'(1);
                        end
                        if (emit)
                        begin
                            pend_next       = mv;
                            pend_valid_next = 1'b1;
                        end
                    end
                end
            end

            ST_FLUSH:
            begin
                res_valid     = 1'b1;
                res.value     = pend_valid_reg ? pend_reg : '0;
                res.has_value = pend_valid_reg;
                res.status    = pend_valid_reg ? STATUS_OK : STATUS_EMPTY;
                res.last      = 1'b1;
                if (res_ready)
                begin
                    pend_valid_next = 1'b0;
                    state_next      = ST_IDLE;
                end
            end

            ST_RESULT:
            begin
                res_valid  = 1'b1;
                res.status = status_reg;
                res.last   = 1'b1;
                if (res_ready)
                begin
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // read address follows the next index so data lines up next cycle
        ins_addr = (state_next == ST_SHIFT) ? (j_next - CW'(1)) : i_next;
        ra_full  = i_next;
        rb_full  = j_next;
        if (state_next == ST_SEARCH || state_next == ST_SHIFT)
        begin
            if (sel_b || (state_next == ST_SEARCH && state_reg == ST_IDLE
                          && in_opcode == OP_INS_B))
            begin
                rb_full = ins_addr;
            end
            else
            begin
                ra_full = ins_addr;
            end
        end
    end

    assign a_raddr = ra_full[AW-1:0];
    assign b_raddr = rb_full[AW-1:0];

endmodule

// ===== rtl/sorted_set_union_intersection_core.sv =====
// top level of the sorted set union / intersection core
// depends on ssui_pkg, ssui_ram, ssui_ctrl
//
// usage: one request on the s_ channel carries an opcode and a value.
// insert into A or B puts the value at its place in a descending set and
// answers with one status result (ok, duplicate, full). union and
// intersection stream the merged values highest first on the m_ channel,
// tlast on the final one; an empty answer is one result with status empty
// and no value. clear empties both sets and answers ok. opcodes 5 to 7 are
// dropped without a result.
// timing: one request at a time; s_tready is high only while idle. an
// insert walks to the slot (search), then shifts from the top entry down
// to it, one entry a cycle; a merge makes one head compare per cycle over
// both rams while the output is not stalled. the next request is taken
// once the final result has gone into the output register. a result sits
// in the output register while the next step goes on; when the receiver
// holds m_tready low the walk waits. reset empties both sets at once, the
// ram contents are left as they are and entries beyond the fill counts
// are never used.
module sorted_set_union_intersection_core
    import ssui_pkg::*;
#(
    parameter int SET_DEPTH = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // value [31:0]
    input  logic [2:0]  s_tuser,   // opcode [2:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // out_value [31:0]
    output logic [2:0]  m_tuser,   // has_value [0], status [2:1]
    output logic        m_tlast
);

    localparam int AW = (SET_DEPTH > 1) ? $clog2(SET_DEPTH) : 1;
    localparam int CW = $clog2(SET_DEPTH + 1);

    logic                     res_valid;
    logic                     res_ready;
    res_t                     res;
    logic [AW-1:0]            a_raddr, b_raddr, wr_addr;
    logic signed [DATA_W-1:0] a_rdata, b_rdata;
    logic [DATA_W-1:0]        a_rdata_raw, b_rdata_raw;
    logic                     a_we, b_we;
    logic [DATA_W-1:0]        wr_data;

    logic                     m_valid_reg, m_valid_next;
    res_t                     m_data_reg, m_data_next;

    assign a_rdata = $signed(a_rdata_raw);
    assign b_rdata = $signed(b_rdata_raw);

    ssui_ram #(
        .WIDTH (DATA_W),
        .DEPTH (SET_DEPTH),
        .AW    (AW)
    ) u_ram_a (
        .clk   (clk),
        .we    (a_we),
        .waddr (wr_addr),
        .wdata (wr_data),
        .raddr (a_raddr),
        .rdata (a_rdata_raw)
    );

    ssui_ram #(
        .WIDTH (DATA_W),
        .DEPTH (SET_DEPTH),
        .AW    (AW)
    ) u_ram_b (
        .clk   (clk),
        .we    (b_we),
        .waddr (wr_addr),
        .wdata (wr_data),
        .raddr (b_raddr),
        .rdata (b_rdata_raw)
    );

    ssui_ctrl #(
        .SET_DEPTH (SET_DEPTH),
        .AW        (AW),
        .CW        (CW)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_opcode (s_tuser),
        .in_value  ($signed(s_tdata)),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .a_raddr   (a_raddr),
        .b_raddr   (b_raddr),
        .a_rdata   (a_rdata),
        .b_rdata   (b_rdata),
        .a_we      (a_we),
        .b_we      (b_we),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data)
    );

    // output register: refills in the same cycle the receiver drains it
    assign res_ready = !m_valid_reg || m_tready;

    always_comb
    begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (res_valid && res_ready)
        begin
            m_valid_next = 1'b1;
            m_data_next  = res;
        end
        else if (m_tready)
        begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else
        begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        m_data_reg <= m_data_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg.value;
    assign m_tuser  = {m_data_reg.status, m_data_reg.has_value};
    assign m_tlast  = m_data_reg.last;

endmodule
